// File: rtl/core/flp_pkg.sv
//------------------------------------------------------------------------------
// Fax line preview package
// Shared widths, command codes, the job record passed from the front end to
// the back end, and the divide-by-three helper.
//------------------------------------------------------------------------------
package flp_pkg;

   localparam int TAPS_PER_LINE_DEF = 500;
   localparam int COLUMN_BITS_DEF   = 16;

   localparam int SAMPLE_W    = 8;
   localparam int SUM_W       = 10;
   localparam int LEVEL_W     = 8;
   localparam int COLOR_W     = 24;
   localparam int CHANNEL_W   = 8;
   localparam int ROW_W       = 9;
   localparam int COLUMN_W    = 16;
   localparam int PAL_INDEX_W = 8;
   localparam int PAL_DEPTH   = 256;
   localparam int QUEUE_DEPTH = 4;

   // Reciprocal of three, exact for floor division of any value below 1024.
   localparam int DIV3_RECIP = 683;
   localparam int DIV3_SHIFT = 11;

   typedef enum logic [1:0] {
      CMD_SAMPLE    = 2'd0,
      CMD_PAL_WRITE = 2'd1,
      CMD_BEGIN     = 2'd2,
      CMD_END       = 2'd3
   } command_type;

   typedef logic [1:0] phase_type;

   localparam phase_type PHASE_FIRST  = 2'd0;
   localparam phase_type PHASE_MIDDLE = 2'd1;
   localparam phase_type PHASE_LAST   = 2'd2;

   typedef struct packed {
      logic                   is_palette;
      phase_type              line_phase;
      logic [SUM_W-1:0]       sum;
      logic [COLUMN_W-1:0]    column;
      logic [ROW_W-1:0]       row;
      logic                   last;
      logic [PAL_INDEX_W-1:0] pal_index;
      logic [COLOR_W-1:0]     pal_color;
   } job_type;

   function automatic logic [LEVEL_W-1:0] div3(input logic [SUM_W-1:0] x);
      logic [2*SUM_W-1:0] p;
      p = (2*SUM_W)'(x) * (2*SUM_W)'(DIV3_RECIP);
      return p[DIV3_SHIFT +: LEVEL_W];
   endfunction

endpackage

// File: rtl/core/flp_front.sv
//------------------------------------------------------------------------------
// Fax line preview front end
// Decodes each command, tracks reception, sample, tap and line phases and the
// column count, and emits a job for every finished tap and palette write.
//------------------------------------------------------------------------------
module flp_front #(
   parameter  int TAPS_PER_LINE = flp_pkg::TAPS_PER_LINE_DEF,
   parameter  int COLUMN_BITS   = flp_pkg::COLUMN_BITS_DEF,
   localparam int IDX_W         = $clog2(TAPS_PER_LINE)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     command,
   input  logic [flp_pkg::SAMPLE_W-1:0]    sample,
   input  logic [flp_pkg::PAL_INDEX_W-1:0] palette_index,
   input  logic [flp_pkg::COLOR_W-1:0]     palette_color,
   output logic                           job_valid,
   output flp_pkg::job_type               job,
   output logic [IDX_W-1:0]               job_index
);
   import flp_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS_PER_LINE - 1);

   command_type              cmd;
   logic                     receiving_ff, receiving_in;
   phase_type                sample_phase_ff, sample_phase_in;
   logic [SUM_W-1:0]         psum_ff, psum_in;
   logic [IDX_W-1:0]         tap_index_ff, tap_index_in;
   phase_type                line_phase_ff, line_phase_in;
   logic [COLUMN_BITS-1:0]   column_ff, column_in;
   logic [SUM_W-1:0]         sample_sum;

   assign cmd        = command_type'(command);
   assign sample_sum = psum_ff + SUM_W'(sample);

   always_comb begin
      receiving_in    = receiving_ff;
      sample_phase_in = sample_phase_ff;
      psum_in         = psum_ff;
      tap_index_in    = tap_index_ff;
      line_phase_in   = line_phase_ff;
      column_in       = column_ff;
      job_valid       = 1'b0;
      if (accept) begin
         case (cmd)
            CMD_PAL_WRITE: begin
               job_valid = 1'b1;
            end
            CMD_BEGIN: begin
               receiving_in    = 1'b1;
               sample_phase_in = PHASE_FIRST;
               psum_in         = '0;
               tap_index_in    = '0;
               line_phase_in   = PHASE_FIRST;
               column_in       = '0;
            end
            CMD_END: begin
               receiving_in = 1'b0;
            end
            CMD_SAMPLE: begin
               if (receiving_ff) begin
                  if (sample_phase_ff != PHASE_LAST) begin
                     sample_phase_in = sample_phase_ff + 2'd1;
                     psum_in         = sample_sum;
                  end else begin
                     sample_phase_in = PHASE_FIRST;
                     psum_in         = '0;
                     job_valid       = 1'b1;
                     if (tap_index_ff == LAST_IDX) begin
                        tap_index_in = '0;
                        if (line_phase_ff == PHASE_LAST) begin
                           line_phase_in = PHASE_FIRST;
                           column_in     = column_ff + COLUMN_BITS'(1);
                        end else begin
                           line_phase_in = line_phase_ff + 2'd1;
                        end
                     end else begin
                        tap_index_in = tap_index_ff + IDX_W'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      job.is_palette = (cmd == CMD_PAL_WRITE);
      job.line_phase = line_phase_ff;
      job.sum        = sample_sum;
      job.column     = COLUMN_W'(column_ff);
      job.row        = ROW_W'(LAST_IDX - tap_index_ff);
      job.last       = (tap_index_ff == LAST_IDX);
      job.pal_index  = palette_index;
      job.pal_color  = palette_color;
      job_index      = tap_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff    <= 1'b0;
         sample_phase_ff <= PHASE_FIRST;
         psum_ff         <= '0;
         tap_index_ff    <= '0;
         line_phase_ff   <= PHASE_FIRST;
         column_ff       <= '0;
      end else begin
         receiving_ff    <= receiving_in;
         sample_phase_ff <= sample_phase_in;
         psum_ff         <= psum_in;
         tap_index_ff    <= tap_index_in;
         line_phase_ff   <= line_phase_in;
         column_ff       <= column_in;
      end
   end

endmodule

// File: rtl/core/flp_queue.sv
//------------------------------------------------------------------------------
// Fax line preview job queue
// A short first-in first-out buffer that decouples the front end from the
// back end.
//------------------------------------------------------------------------------
module flp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = flp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   import flp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/flp_back.sv
//------------------------------------------------------------------------------
// Fax line preview back end
// Accumulates taps over three lines in the tap memory, reduces the sum to a
// level, looks the level up in the palette and holds the pixel for the
// consumer.
//------------------------------------------------------------------------------
module flp_back #(
   parameter  int TAPS_PER_LINE = flp_pkg::TAPS_PER_LINE_DEF,
   localparam int IDX_W         = $clog2(TAPS_PER_LINE)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  flp_pkg::job_type              job,
   input  logic [IDX_W-1:0]              job_index,
   output logic                          job_pop,
   output logic                          empty,
   input  logic                          pop,
   output logic [flp_pkg::COLUMN_W-1:0]  column,
   output logic [flp_pkg::ROW_W-1:0]     row,
   output logic [flp_pkg::CHANNEL_W-1:0] red,
   output logic [flp_pkg::CHANNEL_W-1:0] green,
   output logic [flp_pkg::CHANNEL_W-1:0] blue,
   output logic                          last_of_column
);
   import flp_pkg::*;

   logic [SUM_W-1:0]   acc_mem [TAPS_PER_LINE];
   logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
   logic [PAL_DEPTH-1:0] pal_valid_ff;

   logic               advance;
   logic               a_valid_ff, b_valid_ff, c_valid_ff, out_valid_ff;
   job_type            a_job_ff, b_job_ff, c_job_ff, out_job_ff;
   logic [IDX_W-1:0]   a_index_ff;
   logic [LEVEL_W-1:0] a_tap_ff;
   logic [SUM_W-1:0]   acc_rd_ff;
   logic [SUM_W-1:0]   acc_sum;
   logic [SUM_W-1:0]   b_acc_ff;
   logic [LEVEL_W-1:0] c_level_ff;
   logic [COLOR_W-1:0] pal_rd_ff;
   logic               pal_hit_ff;
   logic [LEVEL_W-1:0] pal_level_ff;
   logic [COLOR_W-1:0] pixel_color;

   assign advance = !out_valid_ff || pop;
   assign job_pop = advance && job_valid;

   // The first line of a group overwrites the entry, so stale contents never
   // reach a pixel.
   assign acc_sum = ((a_job_ff.line_phase == PHASE_FIRST) ? '0 : acc_rd_ff)
                    + SUM_W'(a_tap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         pal_valid_ff <= '0;
      end else if (advance) begin
         a_valid_ff   <= job_pop;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         out_valid_ff <= c_valid_ff && !c_job_ff.is_palette
                         && (c_job_ff.line_phase == PHASE_LAST);
         if (c_valid_ff && c_job_ff.is_palette) begin
            pal_valid_ff[c_job_ff.pal_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_job_ff     <= job;
         a_index_ff   <= job_index;
         a_tap_ff     <= div3(job.sum);
         acc_rd_ff    <= acc_mem[job_index];
         b_job_ff     <= a_job_ff;
         b_acc_ff     <= acc_sum;
         c_job_ff     <= b_job_ff;
         c_level_ff   <= div3(b_acc_ff);
         out_job_ff   <= c_job_ff;
         pal_rd_ff    <= pal_mem[c_level_ff];
         pal_hit_ff   <= pal_valid_ff[c_level_ff];
         pal_level_ff <= c_level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_valid_ff && !a_job_ff.is_palette
          && (a_job_ff.line_phase != PHASE_LAST)) begin
         acc_mem[a_index_ff] <= acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && c_valid_ff && c_job_ff.is_palette) begin
         pal_mem[c_job_ff.pal_index] <= c_job_ff.pal_color;
      end
   end

   // An entry never written yields its gray ramp value.
   assign pixel_color    = pal_hit_ff ? pal_rd_ff
                                      : {pal_level_ff, pal_level_ff, pal_level_ff};
   assign empty          = !out_valid_ff;
   assign column         = out_job_ff.column;
   assign row            = out_job_ff.row;
   assign last_of_column = out_job_ff.last;
   assign red            = pixel_color[2*CHANNEL_W +: CHANNEL_W];
   assign green          = pixel_color[CHANNEL_W +: CHANNEL_W];
   assign blue           = pixel_color[0 +: CHANNEL_W];

endmodule

// File: rtl/core/fax_line_preview_decimator.sv
//------------------------------------------------------------------------------
// Fax line preview decimator
// Reduces received fax lines by three in both directions and turns each
// reduced value into a palette colour for a live preview.
//------------------------------------------------------------------------------
// The block takes one beat per clock cycle, whatever its command, as long as
// full is low. The pixel of the sample beat that ends its tap passes through
// the four-beat job queue and the four back-end stages (accumulator read,
// accumulate and write back, level division, palette read into the result
// register); these stages stall while a waiting pixel sees pop low. Palette
// writes travel through the same queue, so they take effect in beat order.
// No clearing pass is needed after reset: the first line of each group of
// three overwrites the tap memory.
module fax_line_preview_decimator #(
   parameter int TAPS_PER_LINE = flp_pkg::TAPS_PER_LINE_DEF,
   parameter int COLUMN_BITS   = flp_pkg::COLUMN_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [1:0]                     req_command,
   input  logic [flp_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic [flp_pkg::PAL_INDEX_W-1:0] req_palette_index,
   input  logic [flp_pkg::COLOR_W-1:0]     req_palette_color,
   output logic                           empty,
   input  logic                           pop,
   output logic [flp_pkg::COLUMN_W-1:0]    rsp_column,
   output logic [flp_pkg::ROW_W-1:0]       rsp_row,
   output logic [flp_pkg::CHANNEL_W-1:0]   rsp_red,
   output logic [flp_pkg::CHANNEL_W-1:0]   rsp_green,
   output logic [flp_pkg::CHANNEL_W-1:0]   rsp_blue,
   output logic                           rsp_last_of_column
);
   import flp_pkg::*;

   localparam int IDX_W   = $clog2(TAPS_PER_LINE);
   localparam int QUEUE_W = $bits(job_type) + IDX_W;

   logic               accept;
   logic               front_valid;
   job_type            front_job;
   logic [IDX_W-1:0]   front_index;
   logic               queue_empty;
   logic [QUEUE_W-1:0] queue_data;
   job_type            back_job;
   logic [IDX_W-1:0]   back_index;
   logic               back_pop;

   assign accept = push && !full;

   flp_front #(
      .TAPS_PER_LINE (TAPS_PER_LINE),
      .COLUMN_BITS   (COLUMN_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .sample        (req_sample),
      .palette_index (req_palette_index),
      .palette_color (req_palette_color),
      .job_valid     (front_valid),
      .job           (front_job),
      .job_index     (front_index)
   );

   flp_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data ({front_index, front_job}),
      .pop       (back_pop),
      .pop_data  (queue_data),
      .full      (full),
      .empty     (queue_empty)
   );

   assign {back_index, back_job} = queue_data;

   flp_back #(
      .TAPS_PER_LINE (TAPS_PER_LINE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (!queue_empty),
      .job            (back_job),
      .job_index      (back_index),
      .job_pop        (back_pop),
      .empty          (empty),
      .pop            (pop),
      .column         (rsp_column),
      .row            (rsp_row),
      .red            (rsp_red),
      .green          (rsp_green),
      .blue           (rsp_blue),
      .last_of_column (rsp_last_of_column)
   );

endmodule

// File: rtl/core/flp_checker.sv
//------------------------------------------------------------------------------
// Fax line preview port checker
// Watches the ports of the decimator and flags behaviour that the design
// must never show.
//------------------------------------------------------------------------------
module flp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           push,
   input logic                           full,
   input logic                           empty,
   input logic                           pop,
   input logic [flp_pkg::COLUMN_W-1:0]    rsp_column,
   input logic [flp_pkg::ROW_W-1:0]       rsp_row,
   input logic [flp_pkg::CHANNEL_W-1:0]   rsp_red,
   input logic [flp_pkg::CHANNEL_W-1:0]   rsp_green,
   input logic [flp_pkg::CHANNEL_W-1:0]   rsp_blue,
   input logic                           rsp_last_of_column
);
   import flp_pkg::*;

   // Reset leaves no pixel behind.
   a_reset_empty : assert property (@(posedge clock) (!reset && $past(reset)) |-> empty)
      else $error("pixel visible straight after reset");

   // Reset leaves the input side open.
   a_reset_open : assert property (@(posedge clock) (!reset && $past(reset)) |-> !full)
      else $error("input blocked straight after reset");

   // The last pixel of a column always sits on the bottom row.
   a_last_bottom : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_of_column) |-> (rsp_row == '0))
      else $error("last pixel of a column not on row zero");

   // A pixel that is not taken stays put.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_column) && $stable(rsp_row)
                            && $stable(rsp_red) && $stable(rsp_green)
                            && $stable(rsp_blue) && $stable(rsp_last_of_column)))
      else $error("waiting pixel changed or vanished");

endmodule

bind fax_line_preview_decimator flp_checker u_flp_checker (.*);
